/* rtl/ores_pkg.sv */
// ============================================================================
// ores_pkg
// Shared types and constants of the 1-Wire ROM search engine.
// ============================================================================
package ores_pkg;

   localparam int unsigned ROM_W       = 64;
   localparam int unsigned POS_W       = 7;
   localparam int unsigned CRC_W       = 8;
   localparam logic [POS_W-1:0] END_POS = 7'd65;
   localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;   // x^8+x^5+x^4+1, reflected
   localparam logic [7:0] SEARCH_ROM_CMD = 8'hF0;  // issued by the controller

   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 72;
   localparam int unsigned RSP_USER_W = 3;

   // request kinds on the input tuser
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_PAIR  = 1'b1;

   typedef enum logic [2:0] {
      ST_STARTED = 3'd0,
      ST_BIT     = 3'd1,
      ST_FOUND   = 3'd2,
      ST_FAILED  = 3'd3,
      ST_NO_MORE = 3'd4,
      ST_IGNORED = 3'd5
   } status_type;

   // classified operation handed from the front to the back
   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_SPLIT    = 2'd1,  // bits differ: all devices agree on id_bit
      OP_CONFLICT = 2'd2,  // both zero: discrepancy
      OP_NONE     = 2'd3   // both one: nobody answered
   } op_type;

   typedef struct packed {
      op_type op;
      logic   restart;
      logic   presence;
      logic   id_bit;
   } cmd_type;

endpackage

/* rtl/ores_front.sv */
// ============================================================================
// ores_front
// Accepts request items and classifies them into engine commands.
// ============================================================================
module ores_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ores_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [ores_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                push,
   output ores_pkg::cmd_type                   cmd,
   input  logic                                q_full
);
   import ores_pkg::*;

   logic id_bit;
   logic cmp_bit;

   assign id_bit     = req_tdata[2];
   assign cmp_bit    = req_tdata[3];
   assign req_tready = ~q_full;
   assign push       = req_tvalid & ~q_full;

   always_comb begin
      cmd.restart  = req_tdata[0];
      cmd.presence = req_tdata[1];
      cmd.id_bit   = id_bit;
      if (req_tuser[0] == REQ_START) begin
         cmd.op = OP_START;
      end else if (id_bit != cmp_bit) begin
         cmd.op = OP_SPLIT;
      end else if (id_bit) begin
         cmd.op = OP_NONE;
      end else begin
         cmd.op = OP_CONFLICT;
      end
   end

endmodule

/* rtl/ores_queue.sv */
// ============================================================================
// ores_queue
// Short command queue between the front and the back.
// ============================================================================
module ores_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ores_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ores_pkg::cmd_type head
);
   import ores_pkg::*;

   cmd_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_pop;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/ores_back.sv */
// ============================================================================
// ores_back
// Search state, per-bit decision, CRC-8 and the registered result.
// ============================================================================
module ores_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_not_empty,
   input  ores_pkg::cmd_type                 cmd,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ores_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ores_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import ores_pkg::*;

   logic [ROM_W-1:0] rom_ff,      rom_in;
   logic [POS_W-1:0] last_disc_ff, last_disc_in;
   logic             last_dev_ff, last_dev_in;
   logic [POS_W-1:0] pos_ff,      pos_in;
   logic [POS_W-1:0] zero_pos_ff, zero_pos_in;
   logic             active_ff,   active_in;
   logic [CRC_W-1:0] crc_ff,      crc_in;

   logic             out_valid_ff, out_valid_in;
   status_type       status_ff,   status_in;
   logic             dir_ff,      dir_in;
   logic             last_ff,     last_in;

   logic [5:0]       sh;
   logic             dir;
   logic             fb;

   // a new command moves when the result register is free or being emptied
   assign pop = q_not_empty & (~out_valid_ff | rsp_tready);
   assign sh  = pos_ff[5:0] - 6'd1;
   assign fb  = crc_ff[0] ^ dir;

   always_comb begin
      case (cmd.op)
         OP_SPLIT: dir = cmd.id_bit;
         OP_CONFLICT: begin
            if (pos_ff < last_disc_ff) begin
               dir = rom_ff[sh];
            end else begin
               dir = (pos_ff == last_disc_ff);
            end
         end
         default: dir = 1'b0;
      endcase
   end

   always_comb begin
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      last_dev_in  = last_dev_ff;
      pos_in       = pos_ff;
      zero_pos_in  = zero_pos_ff;
      active_in    = active_ff;
      crc_in       = crc_ff;
      status_in    = status_ff;
      dir_in       = dir_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;

      if (pop) begin
         out_valid_in = 1'b1;
         dir_in       = 1'b0;
         last_in      = 1'b0;
         if (cmd.op == OP_START) begin
            pos_in       = 7'd1;
            zero_pos_in  = '0;
            crc_in       = '0;
            active_in    = 1'b0;
            if (last_dev_ff && !cmd.restart) begin
               last_disc_in = '0;
               last_dev_in  = 1'b0;
               status_in    = ST_NO_MORE;
            end else if (!cmd.presence) begin
               last_disc_in = '0;
               last_dev_in  = 1'b0;
               status_in    = ST_FAILED;
            end else begin
               if (cmd.restart) begin
                  last_disc_in = '0;
                  last_dev_in  = 1'b0;
               end
               active_in = 1'b1;
               status_in = ST_STARTED;
            end
         end else if (!active_ff) begin
            status_in = ST_IGNORED;
         end else if (cmd.op == OP_NONE) begin
            active_in    = 1'b0;
            last_disc_in = '0;
            last_dev_in  = 1'b0;
            status_in    = ST_FAILED;
         end else begin
            dir_in      = dir;
            rom_in[sh]  = dir;
            if (cmd.op == OP_CONFLICT && !dir) begin
               zero_pos_in = pos_ff;
            end
            crc_in    = {1'b0, crc_ff[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
            pos_in    = pos_ff + 1'b1;
            status_in = ST_BIT;
            if (pos_in >= END_POS) begin
               active_in = 1'b0;
               if (crc_in == '0 && rom_in[7:0] != '0) begin
                  last_disc_in = zero_pos_in;
                  last_dev_in  = (zero_pos_in == '0) | last_dev_ff;
                  last_in      = (zero_pos_in == '0) | last_dev_ff;
                  status_in    = ST_FOUND;
               end else begin
                  last_disc_in = '0;
                  last_dev_in  = 1'b0;
                  status_in    = ST_FAILED;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff       <= '0;
         last_disc_ff <= '0;
         last_dev_ff  <= 1'b0;
         pos_ff       <= 7'd1;
         zero_pos_ff  <= '0;
         active_ff    <= 1'b0;
         crc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rom_ff       <= rom_in;
         last_disc_ff <= last_disc_in;
         last_dev_ff  <= last_dev_in;
         pos_ff       <= pos_in;
         zero_pos_ff  <= zero_pos_in;
         active_ff    <= active_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      dir_ff    <= dir_in;
      last_ff   <= last_in;
   end

   // the ID register only changes on a pop, so it tracks the held result
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {6'd0, last_ff, rom_ff, dir_ff};

endmodule

/* rtl/onewire_rom_search_engine_unit.sv */
// A result item appears after its request item is accepted, passing first the
//   queue entry and then the result register, when the result register is free.
// Throughput: one item per cycle unless rsp_tready stalls; decision, ID update
//   and CRC-8 step are combinational, and a two-entry queue decouples the sides.
// Reset (synchronous, active high) clears the queue, the result valid flag and
//   all search state: ID and history zero, bit position one, no pass open.
// ============================================================================
// onewire_rom_search_engine_unit
// 1-Wire ROM search decision engine: picks the direction bit for each bit
// pair read from the bus, assembles the 64-bit ROM ID and checks its CRC-8.
// ============================================================================
module onewire_rom_search_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: [0] restart, [1] presence, [2] id_bit, [3] cmp_bit, [7:4] zero
   input  logic [ores_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: [0] req_type (0 start pass, 1 bit pair)
   input  logic [ores_pkg::REQ_USER_W-1:0]   req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: [0] direction, [64:1] rom_id, [65] last_found, [71:66] zero
   output logic [ores_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: [2:0] status
   output logic [ores_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import ores_pkg::*;

   logic    push;
   logic    q_full;
   logic    q_not_empty;
   logic    pop;
   cmd_type front_cmd;
   cmd_type head_cmd;

   // front: handshake and classification of the bit pair
   ores_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .cmd        (front_cmd),
      .q_full     (q_full)
   );

   // queue: lets the request side keep going while a result waits
   ores_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   // back: search state machine data path and result register
   ores_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .cmd         (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

/* rtl/ores_checker.sv */
// ============================================================================
// ores_checker
// Port-level checks of the ROM search engine.
// ============================================================================
module ores_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ores_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [ores_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import ores_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a found device always has a nonzero family code
   a_found_family: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FOUND |-> rsp_tdata[8:1] != 8'd0)
      else $error("device found with zero family code");

   // last_found only accompanies a found device
   a_last_only_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |-> rsp_tuser == ST_FOUND)
      else $error("last_found outside device found");

   // an accepted item into an empty engine answers after the queue and result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && $past(!req_tvalid || !req_tready)
      && $past(!rsp_tvalid) |-> ##2 rsp_tvalid)
      else $error("result missing two cycles after accept");

   // no direction bit reported on a pass start, no-more or ignored result
   a_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_STARTED || rsp_tuser == ST_NO_MORE
      || rsp_tuser == ST_IGNORED) |-> !rsp_tdata[0])
      else $error("direction set on a non-bit result");

endmodule

bind onewire_rom_search_engine_unit ores_checker u_ores_checker (.*);
